[sv/h2fd_pkg.sv]
// Shared types, codes and tables for the HTTP/2 frame header deframer.
// No dependencies; imported by h2fd_hdr_check and http2_frame_deframer.
package h2fd_pkg;

   typedef enum logic [1:0] {
      EvHeader  = 2'd0,
      EvPayload = 2'd1,
      EvError   = 2'd2
   } event_kind_type;

   typedef enum logic [3:0] {
      ClsData         = 4'd0,
      ClsHeaders      = 4'd1,
      ClsContinuation = 4'd2,
      ClsRstStream    = 4'd3,
      ClsSettings     = 4'd4,
      ClsWindowUpdate = 4'd5,
      ClsPing         = 4'd6,
      ClsGoaway       = 4'd7,
      ClsSkip         = 4'd8
   } frame_class_type;

   typedef enum logic [2:0] {
      ErrNone          = 3'd0,
      ErrPreface       = 3'd1,
      ErrContExpected  = 3'd2,
      ErrContStream    = 3'd3,
      ErrContUnexpect  = 3'd4,
      ErrSettingsOnStr = 3'd5
   } error_type;

   // raw frame type codes
   localparam logic [7:0] TypeData         = 8'h00;
   localparam logic [7:0] TypeHeaders      = 8'h01;
   localparam logic [7:0] TypeRstStream    = 8'h03;
   localparam logic [7:0] TypeSettings     = 8'h04;
   localparam logic [7:0] TypePing         = 8'h06;
   localparam logic [7:0] TypeGoaway       = 8'h07;
   localparam logic [7:0] TypeWindowUpdate = 8'h08;
   localparam logic [7:0] TypeContinuation = 8'h09;

   localparam logic [7:0] FlagEndHeaders  = 8'h04;
   localparam logic [7:0] StreamTopMask   = 8'h7f;

   localparam int StreamWidth = 31;
   localparam int LengthWidth = 24;

   typedef struct packed {
      error_type             err;
      frame_class_type       cls;
      logic [StreamWidth-1:0] cont_stream;
   } hdr_chk_type;

   typedef struct packed {
      event_kind_type         kind;
      frame_class_type        cls;
      logic [7:0]             ftype;
      logic [7:0]             flags;
      logic [StreamWidth-1:0] stream;
      logic [LengthWidth-1:0] length;
      logic [7:0]             pbyte;
      logic                   fend;
      logic [StreamWidth-1:0] last_stream;
      error_type              err;
   } rsp_type;

   function automatic frame_class_type class_of(input logic [7:0] t);
      frame_class_type c;
      case (t)
         TypeData:         c = ClsData;
         TypeHeaders:      c = ClsHeaders;
         TypeContinuation: c = ClsContinuation;
         TypeRstStream:    c = ClsRstStream;
         TypeSettings:     c = ClsSettings;
         TypeWindowUpdate: c = ClsWindowUpdate;
         TypePing:         c = ClsPing;
         TypeGoaway:       c = ClsGoaway;
         default:          c = ClsSkip;
      endcase
      return c;
   endfunction

   // client connection preface "PRI * HTTP/2.0\r\n\r\nSM\r\n\r\n"
   function automatic logic [7:0] preface_byte(input logic [4:0] idx);
      logic [7:0] b;
      case (idx)
         5'd0:  b = 8'h50;
         5'd1:  b = 8'h52;
         5'd2:  b = 8'h49;
         5'd3:  b = 8'h20;
         5'd4:  b = 8'h2a;
         5'd5:  b = 8'h20;
         5'd6:  b = 8'h48;
         5'd7:  b = 8'h54;
         5'd8:  b = 8'h54;
         5'd9:  b = 8'h50;
         5'd10: b = 8'h2f;
         5'd11: b = 8'h32;
         5'd12: b = 8'h2e;
         5'd13: b = 8'h30;
         5'd14: b = 8'h0d;
         5'd15: b = 8'h0a;
         5'd16: b = 8'h0d;
         5'd17: b = 8'h0a;
         5'd18: b = 8'h53;
         5'd19: b = 8'h4d;
         5'd20: b = 8'h0d;
         5'd21: b = 8'h0a;
         5'd22: b = 8'h0d;
         5'd23: b = 8'h0a;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[sv/h2fd_hdr_check.sv]
// Frame header check and classification for the HTTP/2 deframer.
// Depends on h2fd_pkg (codes, class table, hdr_chk_type).
module h2fd_hdr_check (
   input  logic [7:0]                     frame_type,
   input  logic [7:0]                     frame_flags,
   input  logic [h2fd_pkg::StreamWidth-1:0] stream_id,
   input  logic [h2fd_pkg::StreamWidth-1:0] cont_stream,
   output h2fd_pkg::hdr_chk_type          chk
);
   import h2fd_pkg::*;

   logic is_cont;
   logic is_hdrs;
   logic end_hdrs;

   assign is_cont  = (frame_type == TypeContinuation);
   assign is_hdrs  = (frame_type == TypeHeaders);
   assign end_hdrs = |(frame_flags & FlagEndHeaders);

   always_comb begin
      chk.cls         = class_of(frame_type);
      chk.err         = ErrNone;
      chk.cont_stream = cont_stream;
      if (cont_stream != '0) begin
         if (!is_cont)
            chk.err = ErrContExpected;
         else if (cont_stream != stream_id)
            chk.err = ErrContStream;
      end else if (is_cont) begin
         chk.err = ErrContUnexpect;
      end else if (frame_type == TypeSettings && stream_id != '0) begin
         chk.err = ErrSettingsOnStr;
      end
      // stream 0 without END_HEADERS leaves nothing to expect
      if (chk.err == ErrNone && (is_hdrs || is_cont))
         chk.cont_stream = end_hdrs ? '0 : stream_id;
   end

endmodule

[sv/http2_frame_deframer.sv]
// HTTP/2 frame header deframer: preface match, 9-byte header assembly, payload pass-through.
// Result beats are registered in the output register, or in the skid entry while it is held.
// Throughput: one byte per clock unless stalled; a two-entry output stage (register plus
// skid) decouples the sides, so req_stall rises only when both entries hold results.
// Reset (synchronous, active high): server role, all state cleared; a csr write restarts
// the frame state with the written role but leaves the output stage untouched.
module http2_frame_deframer (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic                           csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_event_kind,
   output logic [3:0]                     rsp_frame_class,
   output logic [7:0]                     rsp_frame_type,
   output logic [7:0]                     rsp_frame_flags,
   output logic [h2fd_pkg::StreamWidth-1:0] rsp_stream_id,
   output logic [h2fd_pkg::LengthWidth-1:0] rsp_frame_length,
   output logic [7:0]                     rsp_payload_byte,
   output logic                           rsp_frame_end,
   output logic [h2fd_pkg::StreamWidth-1:0] rsp_last_stream_seen,
   output logic [2:0]                     rsp_error_code
);
   import h2fd_pkg::*;

   localparam logic [5:0] PosPreface    = 6'd0;
   localparam logic [5:0] PosHeader     = 6'd24;
   localparam logic [5:0] PosHeaderLast = 6'd32;
   localparam logic [5:0] PosPayload    = 6'd33;

   logic                   expect_ff;
   logic [5:0]             pos_ff, pos_in;
   logic [LengthWidth-1:0] length_ff, length_in;
   logic [7:0]             type_ff, type_in;
   logic [7:0]             flags_ff, flags_in;
   logic [StreamWidth-1:0] stream_ff, stream_in;
   logic [LengthWidth-1:0] remaining_ff, remaining_in;
   logic [StreamWidth-1:0] cont_ff, cont_in;
   logic [StreamWidth-1:0] last_ff, last_in;
   logic                   failed_ff, failed_in;

   rsp_type out_ff, out_in, skid_ff, skid_in, res;
   logic    out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;

   logic                   accept, pop, push;
   logic [3:0]             hdr_idx;
   logic [StreamWidth-1:0] stream_last_byte;
   hdr_chk_type            chk;
   event_kind_type         kind;
   error_type              err;
   logic [7:0]             pbyte;
   logic                   fend;

   assign accept  = req_valid && !skid_valid_ff;
   assign pop     = out_valid_ff && !rsp_stall;
   assign hdr_idx = 4'(pos_ff - PosHeader);
   assign stream_last_byte = {stream_ff[StreamWidth-1:8], req_data_byte};

   h2fd_hdr_check u_check (
      .frame_type  (type_ff),
      .frame_flags (flags_ff),
      .stream_id   (stream_last_byte),
      .cont_stream (cont_ff),
      .chk         (chk)
   );

   always_comb begin
      pos_in       = pos_ff;
      length_in    = length_ff;
      type_in      = type_ff;
      flags_in     = flags_ff;
      stream_in    = stream_ff;
      remaining_in = remaining_ff;
      cont_in      = cont_ff;
      last_in      = last_ff;
      failed_in    = failed_ff;
      push         = 1'b0;
      kind         = EvHeader;
      err          = ErrNone;
      pbyte        = 8'h00;
      fend         = 1'b0;
      if (accept && !failed_ff) begin
         if (pos_ff < PosHeader) begin
            if (req_data_byte != preface_byte(pos_ff[4:0])) begin
               failed_in = 1'b1;
               push      = 1'b1;
               kind      = EvError;
               err       = ErrPreface;
            end else begin
               pos_in = pos_ff + 6'd1;
            end
         end else if (pos_ff < PosPayload) begin
            case (hdr_idx)
               4'd0: length_in = {req_data_byte, 16'h0000};
               4'd1: length_in = {length_ff[23:16], req_data_byte, 8'h00};
               4'd2: length_in = {length_ff[23:8], req_data_byte};
               4'd3: type_in   = req_data_byte;
               4'd4: flags_in  = req_data_byte;
               4'd5: stream_in = {7'(req_data_byte & StreamTopMask), 24'h000000};
               4'd6: stream_in = {stream_ff[30:24], req_data_byte, 16'h0000};
               4'd7: stream_in = {stream_ff[30:16], req_data_byte, 8'h00};
               default: stream_in = stream_last_byte;
            endcase
            if (pos_ff != PosHeaderLast) begin
               pos_in = pos_ff + 6'd1;
            end else if (chk.err != ErrNone) begin
               failed_in = 1'b1;
               push      = 1'b1;
               kind      = EvError;
               err       = chk.err;
            end else begin
               cont_in      = chk.cont_stream;
               if (stream_last_byte != '0)
                  last_in = stream_last_byte;
               remaining_in = length_ff;
               pos_in       = (length_ff == '0) ? PosHeader : PosPayload;
               push         = 1'b1;
               kind         = EvHeader;
               fend         = (length_ff == '0);
            end
         end else begin
            remaining_in = remaining_ff - 1'b1;
            if (remaining_in == '0)
               pos_in = PosHeader;
            push  = 1'b1;
            kind  = EvPayload;
            pbyte = req_data_byte;
            fend  = (remaining_in == '0);
         end
      end
      res.kind        = kind;
      res.cls         = (kind == EvError) ? ClsData : chk.cls;
      res.ftype       = type_in;
      res.flags       = flags_in;
      res.stream      = stream_in;
      res.length      = length_in;
      res.pbyte       = pbyte;
      res.fend        = fend;
      res.last_stream = last_in;
      res.err         = err;
   end

   // output register with a skid entry behind it
   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = res;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = res;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || csr_wr_en) begin
         expect_ff    <= reset ? 1'b1 : csr_wr_data;
         pos_ff       <= (reset || csr_wr_data) ? PosPreface : PosHeader;
         length_ff    <= '0;
         type_ff      <= '0;
         flags_ff     <= '0;
         stream_ff    <= '0;
         remaining_ff <= '0;
         cont_ff      <= '0;
         last_ff      <= '0;
         failed_ff    <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         length_ff    <= length_in;
         type_ff      <= type_in;
         flags_ff     <= flags_in;
         stream_ff    <= stream_in;
         remaining_ff <= remaining_in;
         cont_ff      <= cont_in;
         last_ff      <= last_in;
         failed_ff    <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign req_stall            = skid_valid_ff;
   assign rsp_valid            = out_valid_ff;
   assign rsp_event_kind       = out_ff.kind;
   assign rsp_frame_class      = out_ff.cls;
   assign rsp_frame_type       = out_ff.ftype;
   assign rsp_frame_flags      = out_ff.flags;
   assign rsp_stream_id        = out_ff.stream;
   assign rsp_frame_length     = out_ff.length;
   assign rsp_payload_byte     = out_ff.pbyte;
   assign rsp_frame_end        = out_ff.fend;
   assign rsp_last_stream_seen = out_ff.last_stream;
   assign rsp_error_code       = out_ff.err;

   // skid entry only fills behind a held output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid with empty output register");

   // a sticky failure never produces another beat
   a_no_push_after_fail: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> !push)
      else $error("result produced after connection error");

   // payload phase always has bytes left to pass
   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      (pos_ff == PosPayload) |-> (remaining_ff != '0))
      else $error("payload phase with zero bytes remaining");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= PosPayload)
      else $error("position beyond payload phase");

   // preface matching only exists in the server role
   a_preface_role: assert property (@(posedge clock) disable iff (reset)
      (pos_ff < PosHeader) |-> expect_ff)
      else $error("preface phase without server role");

endmodule
